### rtl/civd_pkg.sv
package civd_pkg;

   localparam int STAGES = 9;

   localparam logic [17:0] ERA_DAYS = 18'd146097;
   localparam logic [17:0] LEAP_ERA_END = 18'd146096;
   localparam logic [17:0] CENTURY_DAYS = 18'd36524;

   // date to day count: year bias of 165 eras, era bias plus epoch shift
   localparam logic [18:0] YEAR_BIAS = 19'd66000;
   localparam logic [25:0] DAYS_BIAS = 26'd24825473;

   // day count to date: epoch shift plus 110 eras, year bias of 110 eras
   localparam logic [25:0] COUNT_BIAS = 26'd16790138;
   localparam logic [17:0] ERA_YEAR_BIAS = 18'd44000;

   // reciprocal multipliers, ceil(2^k / d)
   localparam logic [23:0] DIV400_MUL = 24'(((64'd1 << 32) + 64'd399) / 64'd400);
   localparam logic [26:0] DIVERA_MUL = 27'(((64'd1 << 44) + 64'd146096) / 64'd146097);
   localparam logic [21:0] DIV1460_MUL = 22'(((64'd1 << 32) + 64'd1459) / 64'd1460);
   localparam logic [23:0] DIV365_MUL = 24'(((64'd1 << 32) + 64'd364) / 64'd365);
   localparam logic [12:0] DIV153_MUL = 13'(((64'd1 << 20) + 64'd152) / 64'd153);

   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] SLOT_JAN = 4'd10;

   // first day of each march-based month slot
   function automatic logic [8:0] month_base(input logic [3:0] mp);
      logic [8:0] base;
      case (mp)
         4'd0: base = 9'd0;
         4'd1: base = 9'd31;
         4'd2: base = 9'd61;
         4'd3: base = 9'd92;
         4'd4: base = 9'd122;
         4'd5: base = 9'd153;
         4'd6: base = 9'd184;
         4'd7: base = 9'd214;
         4'd8: base = 9'd245;
         4'd9: base = 9'd275;
         4'd10: base = 9'd306;
         4'd11: base = 9'd337;
         4'd12: base = 9'd367;
         default: base = 9'd0;
      endcase
      return base;
   endfunction

   // year of era divided by 100
   function automatic logic [1:0] div100(input logic [8:0] yoe);
      logic [1:0] q;
      if (yoe >= 9'd300) begin
         q = 2'd3;
      end else if (yoe >= 9'd200) begin
         q = 2'd2;
      end else if (yoe >= 9'd100) begin
         q = 2'd1;
      end else begin
         q = 2'd0;
      end
      return q;
   endfunction

endpackage

### rtl/civd_to_days.sv
module civd_to_days (
   input  logic                         clock,
   input  logic [civd_pkg::STAGES:1]    load,
   input  logic                         clear_out,
   input  logic signed [16:0]           year_in,
   input  logic [3:0]                   month_in,
   input  logic [4:0]                   day_in,
   output logic signed [24:0]           days_out
);

   logic        early;
   logic [3:0]  mp1;
   logic [18:0] ysum1;
   logic [17:0] u1_in, u1_ff;
   logic [9:0]  doy1_in, doy1_ff;

   logic [41:0] prod2;
   logic [8:0]  q2_in, q2_ff;
   logic [17:0] u2_ff;
   logic [9:0]  doy2_ff;

   logic [8:0]  yoe3_in, yoe3_ff;
   logic [8:0]  q3_ff;
   logic [9:0]  doy3_ff;

   logic [18:0] doe4_in, doe4_ff;
   logic [25:0] ebase4_in, ebase4_ff;

   logic [25:0] r5_in, r5_ff;

   logic [24:0] sat6_in;
   logic [24:0] d6_ff, d7_ff, d8_ff, d9_ff;

   // stage 1: shift to march-based year, bias year positive, day of year
   always_comb begin
      early = (month_in <= civd_pkg::MONTH_FEB);
      mp1 = early ? month_in + 4'd9 : month_in - 4'd3;
      ysum1 = {{2{year_in[16]}}, year_in} + civd_pkg::YEAR_BIAS - {18'd0, early};
      u1_in = ysum1[17:0];
      doy1_in = {1'b0, civd_pkg::month_base(mp1)} + {5'd0, day_in} - 10'd1;
   end

   // stage 2: era index by reciprocal multiply
   assign prod2 = u1_ff * civd_pkg::DIV400_MUL;
   assign q2_in = prod2[40:32];

   // stage 3: year of era
   assign yoe3_in = 9'(u2_ff - 18'(q2_ff) * 18'd400);

   // stage 4: day of era and era base
   always_comb begin
      doe4_in = 19'(yoe3_ff) * 19'd365 + 19'(yoe3_ff[8:2])
              - 19'(civd_pkg::div100(yoe3_ff)) + {{9{doy3_ff[9]}}, doy3_ff};
      ebase4_in = 26'(q3_ff) * 26'(civd_pkg::ERA_DAYS);
   end

   // stage 5: day count before clamp
   assign r5_in = ebase4_ff + {{7{doe4_ff[18]}}, doe4_ff} - civd_pkg::DAYS_BIAS;

   // stage 6: clamp to 25 bits
   always_comb begin
      if (!r5_ff[25] && r5_ff[24]) begin
         sat6_in = 25'h0FFFFFF;
      end else if (r5_ff[25] && !r5_ff[24]) begin
         sat6_in = 25'h1000000;
      end else begin
         sat6_in = r5_ff[24:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         u1_ff <= u1_in;
         doy1_ff <= doy1_in;
      end
      if (load[2]) begin
         q2_ff <= q2_in;
         u2_ff <= u1_ff;
         doy2_ff <= doy1_ff;
      end
      if (load[3]) begin
         yoe3_ff <= yoe3_in;
         q3_ff <= q2_ff;
         doy3_ff <= doy2_ff;
      end
      if (load[4]) begin
         doe4_ff <= doe4_in;
         ebase4_ff <= ebase4_in;
      end
      if (load[5]) begin
         r5_ff <= r5_in;
      end
      if (load[6]) begin
         d6_ff <= sat6_in;
      end
      if (load[7]) begin
         d7_ff <= d6_ff;
      end
      if (load[8]) begin
         d8_ff <= d7_ff;
      end
      if (load[9]) begin
         d9_ff <= clear_out ? 25'd0 : d8_ff;
      end
   end

   assign days_out = $signed(d9_ff);

endmodule

### rtl/civd_to_date.sv
module civd_to_date (
   input  logic                         clock,
   input  logic [civd_pkg::STAGES:1]    load,
   input  logic                         clear_out,
   input  logic signed [24:0]           days_in,
   output logic signed [16:0]           year_out,
   output logic [3:0]                   month_out,
   output logic [4:0]                   day_out
);

   logic [25:0] u1_in, u1_ff;

   logic [52:0] prod2;
   logic [7:0]  q2_in, q2_ff;
   logic [25:0] u2_ff;

   logic [17:0] doe3_in, doe3_ff;
   logic [7:0]  q3_ff;

   logic [39:0] prod4;
   logic [6:0]  n4_in, n4_ff;
   logic [2:0]  c4_in, c4_ff;
   logic        dl4_in, dl4_ff;
   logic [17:0] doe4_ff;
   logic [7:0]  q4_ff;

   logic [17:0] num5_in, num5_ff;
   logic [17:0] doe5_ff;
   logic [7:0]  q5_ff;

   logic [41:0] prod6;
   logic [8:0]  yoe6_in, yoe6_ff;
   logic [17:0] doe6_ff;
   logic [7:0]  q6_ff;

   logic [8:0]  doy7_in, doy7_ff;
   logic [8:0]  yoe7_ff;
   logic [7:0]  q7_ff;

   logic [10:0] lin8;
   logic [23:0] prod8;
   logic [3:0]  mp8_in, mp8_ff;
   logic [8:0]  doy8_ff;
   logic [8:0]  yoe8_ff;
   logic [7:0]  q8_ff;

   logic        late9;
   logic [8:0]  dsum9;
   logic [3:0]  mon9;
   logic [17:0] ysum9;
   logic [16:0] year9_ff;
   logic [3:0]  month9_ff;
   logic [4:0]  day9_ff;

   // stage 1: shift epoch to march 0000 and bias positive
   assign u1_in = {days_in[24], days_in} + civd_pkg::COUNT_BIAS;

   // stage 2: era index by reciprocal multiply
   assign prod2 = u1_ff * civd_pkg::DIVERA_MUL;
   assign q2_in = prod2[51:44];

   // stage 3: day of era
   assign doe3_in = 18'(u2_ff - 26'(q2_ff) * 26'(civd_pkg::ERA_DAYS));

   // stage 4: leap corrections
   always_comb begin
      prod4 = doe3_ff * civd_pkg::DIV1460_MUL;
      n4_in = prod4[38:32];
      c4_in = {2'd0, doe3_ff >= civd_pkg::CENTURY_DAYS}
            + {2'd0, doe3_ff >= 18'd73048}
            + {2'd0, doe3_ff >= 18'd109572}
            + {2'd0, doe3_ff >= civd_pkg::LEAP_ERA_END};
      dl4_in = (doe3_ff == civd_pkg::LEAP_ERA_END);
   end

   // stage 5
   assign num5_in = doe4_ff - 18'(n4_ff) + 18'(c4_ff) - 18'(dl4_ff);

   // stage 6: year of era
   assign prod6 = num5_ff * civd_pkg::DIV365_MUL;
   assign yoe6_in = prod6[40:32];

   // stage 7: day of march-based year
   assign doy7_in = 9'(doe6_ff - (18'(yoe6_ff) * 18'd365 + 18'(yoe6_ff[8:2])
                    - 18'(civd_pkg::div100(yoe6_ff))));

   // stage 8: month slot
   always_comb begin
      lin8 = 11'(doy7_ff) * 11'd5 + 11'd2;
      prod8 = lin8 * civd_pkg::DIV153_MUL;
      mp8_in = prod8[23:20];
   end

   // stage 9: civil date
   always_comb begin
      late9 = (mp8_ff >= civd_pkg::SLOT_JAN);
      mon9 = late9 ? mp8_ff - 4'd9 : mp8_ff + 4'd3;
      dsum9 = doy8_ff - civd_pkg::month_base(mp8_ff) + 9'd1;
      ysum9 = 18'(yoe8_ff) + 18'(q8_ff) * 18'd400 - civd_pkg::ERA_YEAR_BIAS
            + {17'd0, late9};
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         u1_ff <= u1_in;
      end
      if (load[2]) begin
         q2_ff <= q2_in;
         u2_ff <= u1_ff;
      end
      if (load[3]) begin
         doe3_ff <= doe3_in;
         q3_ff <= q2_ff;
      end
      if (load[4]) begin
         n4_ff <= n4_in;
         c4_ff <= c4_in;
         dl4_ff <= dl4_in;
         doe4_ff <= doe3_ff;
         q4_ff <= q3_ff;
      end
      if (load[5]) begin
         num5_ff <= num5_in;
         doe5_ff <= doe4_ff;
         q5_ff <= q4_ff;
      end
      if (load[6]) begin
         yoe6_ff <= yoe6_in;
         doe6_ff <= doe5_ff;
         q6_ff <= q5_ff;
      end
      if (load[7]) begin
         doy7_ff <= doy7_in;
         yoe7_ff <= yoe6_ff;
         q7_ff <= q6_ff;
      end
      if (load[8]) begin
         mp8_ff <= mp8_in;
         doy8_ff <= doy7_ff;
         yoe8_ff <= yoe7_ff;
         q8_ff <= q7_ff;
      end
      if (load[9]) begin
         year9_ff <= clear_out ? 17'd0 : ysum9[16:0];
         month9_ff <= clear_out ? 4'd0 : mon9;
         day9_ff <= clear_out ? 5'd0 : dsum9[4:0];
      end
   end

   assign year_out = $signed(year9_ff);
   assign month_out = month9_ff;
   assign day_out = day9_ff;

endmodule

### rtl/civil_date_day_count_converter_core.sv
// each accepted request moves through all pipeline stages to its response
// throughput: one transaction per cycle while rsp_stall is low; no stall source inside the pipeline
// stall backs up stage by stage; empty stages keep filling while a response waits
// reset clears the stage valid bits only; no other state
module civil_date_day_count_converter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [16:0] req_year_in,
   input  logic [3:0]         req_month_in,
   input  logic [4:0]         req_day_in,
   input  logic signed [24:0] req_days_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [24:0] rsp_days_out,
   output logic signed [16:0] rsp_year_out,
   output logic [3:0]         rsp_month_out,
   output logic [4:0]         rsp_day_out
);

   logic [civd_pkg::STAGES:1]   free;
   logic [civd_pkg::STAGES:1]   v_in, v_ff;
   logic [civd_pkg::STAGES-1:1] cmd_in, cmd_ff;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      free[civd_pkg::STAGES] = !v_ff[civd_pkg::STAGES] || !rsp_stall;
      for (int i = civd_pkg::STAGES - 1; i >= 1; i--) begin
         free[i] = !v_ff[i] || free[i+1];
      end
   end

   always_comb begin
      v_in[1] = free[1] ? req_valid : v_ff[1];
      for (int i = 2; i <= civd_pkg::STAGES; i++) begin
         v_in[i] = free[i] ? v_ff[i-1] : v_ff[i];
      end
      cmd_in[1] = free[1] ? req_cmd : cmd_ff[1];
      for (int i = 2; i <= civd_pkg::STAGES - 1; i++) begin
         cmd_in[i] = free[i] ? cmd_ff[i-1] : cmd_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      cmd_ff <= cmd_in;
   end

   assign req_stall = !free[1];
   assign rsp_valid = v_ff[civd_pkg::STAGES];

   civd_to_days u_to_days (
      .clock     (clock),
      .load      (free),
      .clear_out (cmd_ff[civd_pkg::STAGES-1]),
      .year_in   (req_year_in),
      .month_in  (req_month_in),
      .day_in    (req_day_in),
      .days_out  (rsp_days_out)
   );

   civd_to_date u_to_date (
      .clock     (clock),
      .load      (free),
      .clear_out (!cmd_ff[civd_pkg::STAGES-1]),
      .days_in   (req_days_in),
      .year_out  (rsp_year_out),
      .month_out (rsp_month_out),
      .day_out   (rsp_day_out)
   );

endmodule
